// ===== hw/rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Holds the operation codes, the transfer payloads and the divider stage state.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned WORD      = 32;
	// quotient width of (|a| << F) / |b|
	localparam int unsigned QW        = WORD + FRAC_BITS;
	// decode, multiply, multiply finish, QW divide steps, output
	localparam int unsigned NSTAGES   = QW + 4;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_GT      = 4'd4,
		OP_LT      = 4'd5,
		OP_GE      = 4'd6,
		OP_LE      = 4'd7,
		OP_EQ      = 4'd8,
		OP_NE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	typedef struct packed {
		op_t                action;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               compare_true;
		logic               divide_by_zero;
	} rsp_t;

	// state carried through the divide steps
	typedef struct packed {
		logic              is_div;
		logic              neg;
		logic              dz;
		logic              cmp;
		logic [WORD-1:0]   res;
		logic [WORD-1:0]   divisor;
		logic [WORD-1:0]   rem;
		logic [QW-1:0]     dq;
	} div_st_t;

endpackage

// ===== hw/rtl/fpa_div_step.sv =====
// ----------------------------------------------------------------------------
// fpa_div_step: one restoring division step
// Shifts one dividend bit into the remainder and produces one quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_step (
	input  fpa_pkg::div_st_t d,
	output fpa_pkg::div_st_t q
);

	logic [fpa_pkg::WORD:0]   rem_sh;
	logic [fpa_pkg::WORD+1:0] diff;
	logic                     ge;

	always_comb begin
		rem_sh = {d.rem, d.dq[fpa_pkg::QW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, d.divisor};
		ge     = ~diff[fpa_pkg::WORD+1];
		q      = d;
		q.rem  = ge ? diff[fpa_pkg::WORD-1:0] : rem_sh[fpa_pkg::WORD-1:0];
		q.dq   = {d.dq[fpa_pkg::QW-2:0], ge};
	end

endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined fixed-point arithmetic unit on 32-bit words
// Every operation passes the same pipeline; division is one quotient bit per stage.
// ----------------------------------------------------------------------------
// Every operation passes all NSTAGES stages, whose depth is set by the
// restoring divider, one bit per stage. Throughput: one item per cycle
// while rsp_stall is low; a stage advances when empty or the next advances.
// Reset clears the stage valid bits only; no clearing pass is needed.
module fixed_point_alu (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fpa_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fpa_pkg::rsp_t  rsp
);

	localparam int unsigned NS = fpa_pkg::NSTAGES;
	localparam int unsigned QW = fpa_pkg::QW;
	localparam int unsigned FB = fpa_pkg::FRAC_BITS;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vld_in;
	logic [NS:0]   adv;

	always_comb begin
		adv[NS] = ~rsp_stall;
		for (int i = NS - 1; i >= 0; i--) begin
			adv[i] = ~vld_q[i] | adv[i+1];
		end
	end

	assign req_stall = ~adv[0];
	assign vld_in    = {vld_q[NS-2:0], req_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// ---- stage 1: decode, simple operations, magnitudes ----
	logic [31:0] ua, ub, mag_a, mag_b, simple_res;
	logic        lt_ab, eq_ab, cmp_c;

	always_comb begin
		ua         = req.operand_a;
		ub         = req.operand_b;
		mag_a      = req.operand_a[31] ? (32'd0 - ua) : ua;
		mag_b      = req.operand_b[31] ? (32'd0 - ub) : ub;
		lt_ab      = req.operand_a < req.operand_b;
		eq_ab      = ua == ub;
		simple_res = '0;
		cmp_c      = 1'b0;
		unique case (req.action)
			fpa_pkg::OP_ADD:     simple_res = ua + ub;
			fpa_pkg::OP_SUB:     simple_res = ua - ub;
			fpa_pkg::OP_MUL:     simple_res = '0;
			fpa_pkg::OP_DIV:     simple_res = '0;
			fpa_pkg::OP_GT:      cmp_c = ~lt_ab & ~eq_ab;
			fpa_pkg::OP_LT:      cmp_c = lt_ab;
			fpa_pkg::OP_GE:      cmp_c = ~lt_ab;
			fpa_pkg::OP_LE:      cmp_c = lt_ab | eq_ab;
			fpa_pkg::OP_EQ:      cmp_c = eq_ab;
			fpa_pkg::OP_NE:      cmp_c = ~eq_ab;
			fpa_pkg::OP_MIN:     simple_res = lt_ab ? ua : ub;
			fpa_pkg::OP_MAX:     simple_res = (~lt_ab & ~eq_ab) ? ua : ub;
			fpa_pkg::OP_INC:     simple_res = ua + 32'd1;
			fpa_pkg::OP_DEC:     simple_res = ua - 32'd1;
			fpa_pkg::OP_TOINT:   simple_res = 32'(req.operand_a >>> FB);
			fpa_pkg::OP_FROMINT: simple_res = ua << FB;
		endcase
	end

	logic        is_mul_s1, is_div_s1, neg_s1, dz_s1, cmp_s1;
	logic [31:0] res_s1, mag_a_s1, mag_b_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			is_mul_s1 <= req.action == fpa_pkg::OP_MUL;
			is_div_s1 <= req.action == fpa_pkg::OP_DIV;
			neg_s1    <= req.operand_a[31] ^ req.operand_b[31];
			dz_s1     <= (req.action == fpa_pkg::OP_DIV) && (ub == '0);
			cmp_s1    <= cmp_c;
			res_s1    <= simple_res;
			mag_a_s1  <= mag_a;
			mag_b_s1  <= mag_b;
		end
	end

	// ---- stage 2: magnitude product ----
	logic        is_mul_s2, is_div_s2, neg_s2, dz_s2, cmp_s2;
	logic [31:0] res_s2, mag_a_s2, mag_b_s2;
	logic [63:0] prod_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			is_mul_s2 <= is_mul_s1;
			is_div_s2 <= is_div_s1;
			neg_s2    <= neg_s1;
			dz_s2     <= dz_s1;
			cmp_s2    <= cmp_s1;
			res_s2    <= res_s1;
			mag_a_s2  <= mag_a_s1;
			mag_b_s2  <= mag_b_s1;
			prod_s2   <= mag_a_s1 * mag_b_s1;
		end
	end

	// ---- stage 3: finish multiply, load the divider ----
	logic [31:0]      mul_mag;
	fpa_pkg::div_st_t div_init;

	always_comb begin
		mul_mag          = prod_s2[FB+31:FB];
		div_init.is_div  = is_div_s2;
		div_init.neg     = neg_s2;
		div_init.dz      = dz_s2;
		div_init.cmp     = cmp_s2;
		div_init.res     = is_mul_s2 ? (neg_s2 ? (32'd0 - mul_mag) : mul_mag) : res_s2;
		div_init.divisor = mag_b_s2;
		div_init.rem     = '0;
		div_init.dq      = {mag_a_s2, {FB{1'b0}}};
	end

	fpa_pkg::div_st_t dst_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dst_s3 <= div_init;
		end
	end

	// ---- divide steps ----
	fpa_pkg::div_st_t stp_in  [QW];
	fpa_pkg::div_st_t stp_out [QW];
	fpa_pkg::div_st_t stp_s   [QW];

	for (genvar g = 0; g < QW; g++) begin : g_div
		if (g == 0) begin : g_first
			assign stp_in[g] = dst_s3;
		end else begin : g_rest
			assign stp_in[g] = stp_s[g-1];
		end

		fpa_div_step u_step (
			.d (stp_in[g]),
			.q (stp_out[g])
		);

		always_ff @(posedge clk) begin
			if (adv[g+3]) begin
				stp_s[g] <= stp_out[g];
			end
		end
	end

	// ---- output stage: apply quotient sign, select ----
	fpa_pkg::div_st_t fin;
	logic [31:0]      quo;
	fpa_pkg::rsp_t    rsp_c, rsp_s;

	always_comb begin
		fin                  = stp_s[QW-1];
		quo                  = fin.dq[31:0];
		rsp_c.compare_true   = fin.cmp;
		rsp_c.divide_by_zero = fin.dz;
		if (fin.is_div) begin
			rsp_c.result = fin.dz ? '0 : (fin.neg ? (32'd0 - quo) : quo);
		end else begin
			rsp_c.result = fin.res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			rsp_s <= rsp_c;
		end
	end

	assign rsp_valid = vld_q[NS-1];
	assign rsp       = rsp_s;

	// ---- checks ----
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.divide_by_zero || rsp.result == '0))
		else $error("divide by zero with non-zero result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.compare_true && rsp.divide_by_zero))
		else $error("compare and divide-by-zero flags both set");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0] |-> !req_stall)
		else $error("empty first stage refuses a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule
